// File: sv/dds_pkg.sv
// shared types and constants of the wheel speed controller
`default_nettype none

package dds_pkg;

    localparam int ALU_W = 64;

    typedef enum logic {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

endpackage

`default_nettype wire

// File: sv/diff_drive_wheel_speed_pi.sv
// top level: differential drive wheel speed pid controller with target limiting
// ticks: one at a time, a new one only once the last has finished; every multiply
// and every divide runs in the shared bit-serial unit
// reset: synchronous active low; clears targets, integrators, errors and registers
// to their defaults; a finished result may wait in the output register while a new tick is taken
`default_nettype none

module diff_drive_wheel_speed_pi #(
    parameter int PULSES_PER_REV = 1530,
    parameter int TICK_RATE_HZ   = 10
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input item channel
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_cmd,
    input  wire logic signed [23:0] i_target_left,
    input  wire logic signed [23:0] i_target_right,
    input  wire logic signed [15:0] i_pulses_left,
    input  wire logic signed [15:0] i_pulses_right,
    // result channel
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [15:0]      o_duty_left,
    output logic signed [15:0]      o_duty_right,
    output logic signed [23:0]      o_odom_linear,
    output logic signed [23:0]      o_odom_angular,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import dds_pkg::*;

    // fixed scale factors
    localparam logic signed [63:0] TWO_PI_Q32  = 64'sd26986075409;
    localparam logic signed [63:0] MAX_PID_Q16 = 64'sd1235324;
    localparam logic signed [15:0] DUTY_GUARD  = 16'sd328;
    localparam logic signed [15:0] DUTY_MAX    = 16'sd32767;
    localparam logic [63:0]        LIN_K_Q24   = 64'd754975;
    localparam logic [63:0]        ANG_K_Q24   = 64'd3973551;
    localparam logic [63:0]        ODOM_DIV    = 64'd16777216;
    // scale factors that follow from the tick rate and encoder resolution
    localparam logic signed [63:0] SPD_K   = 64'(TICK_RATE_HZ) * TWO_PI_Q32;
    localparam logic [63:0]        SPD_D   = 64'(PULSES_PER_REV) * 64'd65536;
    localparam logic [63:0]        PID_D   = 64'(256 * TICK_RATE_HZ);
    localparam logic signed [63:0] TICK_K  = 64'(TICK_RATE_HZ);
    localparam logic signed [63:0] TICK2_K = 64'(TICK_RATE_HZ * TICK_RATE_HZ);

    // register indexes
    localparam logic [2:0] REG_KP   = 3'd0;
    localparam logic [2:0] REG_KI   = 3'd1;
    localparam logic [2:0] REG_KD   = 3'd2;
    localparam logic [2:0] REG_STEP = 3'd3;
    localparam logic [2:0] REG_TOP  = 3'd4;
    localparam logic [2:0] REG_ILIM = 3'd5;

    typedef enum logic [4:0] {
        S_IDLE,
        S_NT_PREP,
        S_NT_MUL,
        S_NT_DIV,
        S_NT_TOP,
        S_NT_MUL2,
        S_NT_DIV2,
        S_NT_STORE,
        S_SP_MUL,
        S_SP_DIV,
        S_OD_MUL,
        S_OD_DIV,
        S_PI_ERR,
        S_PI_MP,
        S_PI_MI,
        S_PI_MD,
        S_PI_DIV,
        S_PI_DUTY,
        S_FINISH
    } t_state;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        if (v > 64'sd8388607) begin
            return 24'sd8388607;
        end else if (v < -64'sd8388608) begin
            return -24'sd8388608;
        end
        return v[23:0];
    endfunction

    function automatic logic [25:0] abs26(input logic signed [25:0] v);
        return v[25] ? 26'(-v) : 26'(v);
    endfunction

    // configuration registers
    logic [15:0] r_kp, r_ki, r_kd;
    logic [22:0] r_step, r_top, r_ilim;

    // controller state
    t_state             r_state;
    logic               r_wait;
    logic               r_w;
    logic signed [23:0] r_held [2];
    logic signed [23:0] r_prev [2];
    logic signed [23:0] r_acc  [2];
    logic signed [23:0] r_pe   [2];

    // working registers of one tick
    logic signed [23:0] r_tl, r_tr;
    logic signed [15:0] r_pl, r_pr;
    logic signed [25:0] r_ad [2];
    logic signed [25:0] r_d  [2];
    logic        [25:0] r_big;
    logic signed [63:0] r_prod;
    logic signed [23:0] r_wl, r_wr;
    logic signed [23:0] r_lin, r_ang;
    logic signed [23:0] r_e;
    logic signed [63:0] r_tot;
    logic signed [21:0] r_pid;
    logic signed [15:0] r_duty [2];

    // output register
    logic               r_out_valid;
    logic signed [15:0] r_o_dl, r_o_dr;
    logic signed [23:0] r_o_lin, r_o_ang;

    // shared arithmetic unit
    t_alu_req           w_req;
    logic signed [63:0] w_a;
    logic        [63:0] w_b;
    logic               w_done;
    logic signed [63:0] w_res;

    dds_muldiv u_muldiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // combinational helpers
    logic signed [25:0] w_a0, w_a1;
    logic        [25:0] w_big0, w_big2;
    logic signed [23:0] w_cur, w_tgt, w_e;
    logic signed [63:0] w_accsum, w_lim;
    logic signed [23:0] w_accn;
    logic signed [63:0] w_pidc, w_dutyc;
    logic signed [15:0] w_duty;
    logic               w_alu_state;

    always_comb begin
        w_a0   = 26'(r_tl) - 26'(r_prev[0]);
        w_a1   = 26'(r_tr) - 26'(r_prev[1]);
        w_big0 = (abs26(w_a0) > abs26(w_a1)) ? abs26(w_a0) : abs26(w_a1);
        w_big2 = (abs26(r_d[0]) > abs26(r_d[1])) ? abs26(r_d[0]) : abs26(r_d[1]);

        w_cur    = r_w ? r_wr : r_wl;
        w_tgt    = r_held[r_w];
        w_e      = sat24(64'(w_tgt) - 64'(w_cur));
        // integrator with symmetric clamp
        w_lim    = signed'({41'b0, r_ilim});
        w_accsum = 64'(r_acc[r_w]) + 64'(w_e);
        if (w_accsum > w_lim) begin
            w_accn = w_lim[23:0];
        end else if (w_accsum < -w_lim) begin
            w_accn = 24'(-w_lim);
        end else begin
            w_accn = w_accsum[23:0];
        end

        if (w_res > MAX_PID_Q16) begin
            w_pidc = MAX_PID_Q16;
        end else if (w_res < -MAX_PID_Q16) begin
            w_pidc = -MAX_PID_Q16;
        end else begin
            w_pidc = w_res;
        end

        if (w_res > 64'(DUTY_MAX)) begin
            w_dutyc = 64'(DUTY_MAX);
        end else if (w_res < -64'(DUTY_MAX)) begin
            w_dutyc = -64'(DUTY_MAX);
        end else begin
            w_dutyc = w_res;
        end
        // sign guard against driving against the target
        w_duty = w_dutyc[15:0];
        if (w_tgt > 24'sd0 && w_duty < 16'sd0) begin
            w_duty = DUTY_GUARD;
        end else if (w_tgt < 24'sd0 && w_duty > 16'sd0) begin
            w_duty = -DUTY_GUARD;
        end
    end

    // operand selection for the arithmetic unit
    always_comb begin
        w_alu_state = 1'b1;
        w_req.op    = ALU_MUL;
        w_a         = '0;
        w_b         = '0;
        case (r_state)
            S_NT_MUL: begin
                w_a = 64'(r_ad[r_w]);
                w_b = {41'b0, r_step};
            end
            S_NT_DIV, S_NT_DIV2: begin
                w_req.op = ALU_DIV;
                w_a      = r_prod;
                w_b      = {38'b0, r_big};
            end
            S_NT_MUL2: begin
                w_a = 64'(r_d[r_w]);
                w_b = {41'b0, r_top};
            end
            S_SP_MUL: begin
                w_a = SPD_K;
                w_b = r_w ? 64'(r_pr) : 64'(r_pl);
            end
            S_SP_DIV: begin
                w_req.op = ALU_DIV;
                w_a      = r_prod;
                w_b      = SPD_D;
            end
            S_OD_MUL: begin
                w_a = r_w ? (64'(r_wr) - 64'(r_wl)) : (64'(r_wr) + 64'(r_wl));
                w_b = r_w ? ANG_K_Q24 : LIN_K_Q24;
            end
            S_OD_DIV: begin
                w_req.op = ALU_DIV;
                w_a      = r_prod;
                w_b      = ODOM_DIV;
            end
            S_PI_MP: begin
                w_a = 64'(r_e) * TICK_K;
                w_b = {48'b0, r_kp};
            end
            S_PI_MI: begin
                w_a = 64'(r_acc[r_w]);
                w_b = {48'b0, r_ki};
            end
            S_PI_MD: begin
                w_a = (64'(r_e) - 64'(r_pe[r_w])) * TICK2_K;
                w_b = {48'b0, r_kd};
            end
            S_PI_DIV: begin
                w_req.op = ALU_DIV;
                w_a      = r_tot;
                w_b      = PID_D;
            end
            S_PI_DUTY: begin
                w_req.op = ALU_DIV;
                w_a      = (64'(r_pid) + 64'(r_held[r_w])) <<< 15;
                w_b      = MAX_PID_Q16;
            end
            default: begin
                w_alu_state = 1'b0;
            end
        endcase
        // one start per operation, then wait for done
        w_req.start = w_alu_state && !r_wait;
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_duty_left    = r_o_dl;
    assign o_duty_right   = r_o_dr;
    assign o_odom_linear  = r_o_lin;
    assign o_odom_angular = r_o_ang;
    assign pready         = 1'b1;

    // register read back
    always_comb begin
        case (paddr[4:2])
            REG_KP:   prdata = {16'b0, r_kp};
            REG_KI:   prdata = {16'b0, r_ki};
            REG_KD:   prdata = {16'b0, r_kd};
            REG_STEP: prdata = {9'b0, r_step};
            REG_TOP:  prdata = {9'b0, r_top};
            REG_ILIM: prdata = {9'b0, r_ilim};
            default:  prdata = '0;
        endcase
    end

    // configuration writes on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= 16'd256;
            r_ki   <= 16'd461;
            r_kd   <= 16'd0;
            r_step <= 23'd291271;
            r_top  <= 23'd1165084;
            r_ilim <= 23'd6176768;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
                REG_KP:   r_kp   <= pwdata[15:0];
                REG_KI:   r_ki   <= pwdata[15:0];
                REG_KD:   r_kd   <= pwdata[15:0];
                REG_STEP: r_step <= pwdata[22:0];
                REG_TOP:  r_top  <= pwdata[22:0];
                REG_ILIM: r_ilim <= pwdata[22:0];
                default: begin
                end
            endcase
        end
    end

    // sequencer: state, working registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_w         <= 1'b0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 2; i++) begin
                r_held[i] <= '0;
                r_prev[i] <= '0;
                r_acc[i]  <= '0;
                r_pe[i]   <= '0;
            end
        end else begin
            // the finish step reloads the output register itself
            if (r_out_valid && i_out_ready && r_state != S_FINISH) begin
                r_out_valid <= 1'b0;
            end
            if (w_req.start) begin
                r_wait <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tl    <= i_target_left;
                        r_tr    <= i_target_right;
                        r_pl    <= i_pulses_left;
                        r_pr    <= i_pulses_right;
                        r_w     <= 1'b0;
                        r_state <= i_cmd ? S_NT_PREP : S_SP_MUL;
                    end
                end
                // rate limit: scale both changes by the larger one
                S_NT_PREP: begin
                    r_ad[0] <= w_a0;
                    r_ad[1] <= w_a1;
                    r_big   <= w_big0;
                    r_w     <= 1'b0;
                    if (w_big0 > {3'b0, r_step}) begin
                        r_state <= S_NT_MUL;
                    end else begin
                        r_d[0]  <= 26'(r_tl);
                        r_d[1]  <= 26'(r_tr);
                        r_state <= S_NT_TOP;
                    end
                end
                S_NT_MUL: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_prod  <= w_res;
                        r_state <= S_NT_DIV;
                    end
                end
                S_NT_DIV: begin
                    if (r_wait && w_done) begin
                        r_wait      <= 1'b0;
                        r_d[r_w]    <= 26'(r_prev[r_w]) + w_res[25:0];
                        r_w         <= ~r_w;
                        r_state     <= r_w ? S_NT_TOP : S_NT_MUL;
                    end
                end
                // speed limit keeping the left to right ratio
                S_NT_TOP: begin
                    r_big <= w_big2;
                    r_w   <= 1'b0;
                    if (w_big2 > {3'b0, r_top}) begin
                        r_state <= S_NT_MUL2;
                    end else begin
                        r_state <= S_NT_STORE;
                    end
                end
                S_NT_MUL2: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_prod  <= w_res;
                        r_state <= S_NT_DIV2;
                    end
                end
                S_NT_DIV2: begin
                    if (r_wait && w_done) begin
                        r_wait   <= 1'b0;
                        r_d[r_w] <= w_res[25:0];
                        r_w      <= ~r_w;
                        r_state  <= r_w ? S_NT_STORE : S_NT_MUL2;
                    end
                end
                S_NT_STORE: begin
                    for (int i = 0; i < 2; i++) begin
                        r_held[i] <= sat24(64'(r_d[i]));
                        r_prev[i] <= sat24(64'(r_d[i]));
                    end
                    r_w     <= 1'b0;
                    r_state <= S_SP_MUL;
                end
                // pulses to wheel speed
                S_SP_MUL: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_prod  <= w_res;
                        r_state <= S_SP_DIV;
                    end
                end
                S_SP_DIV: begin
                    if (r_wait && w_done) begin
                        r_wait <= 1'b0;
                        if (r_w) begin
                            r_wr <= sat24(w_res);
                        end else begin
                            r_wl <= sat24(w_res);
                        end
                        r_w     <= ~r_w;
                        r_state <= r_w ? S_OD_MUL : S_SP_MUL;
                    end
                end
                // odometry: linear on the first pass, angular on the second
                S_OD_MUL: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_prod  <= w_res;
                        r_state <= S_OD_DIV;
                    end
                end
                S_OD_DIV: begin
                    if (r_wait && w_done) begin
                        r_wait <= 1'b0;
                        if (r_w) begin
                            r_ang <= sat24(w_res);
                        end else begin
                            r_lin <= sat24(w_res);
                        end
                        r_w     <= ~r_w;
                        r_state <= r_w ? S_PI_ERR : S_OD_MUL;
                    end
                end
                // pid for the wheel in r_w
                S_PI_ERR: begin
                    r_e        <= w_e;
                    r_acc[r_w] <= w_accn;
                    r_tot      <= '0;
                    r_state    <= S_PI_MP;
                end
                S_PI_MP: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_tot   <= r_tot + w_res;
                        r_state <= S_PI_MI;
                    end
                end
                S_PI_MI: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_tot   <= r_tot + w_res;
                        r_state <= S_PI_MD;
                    end
                end
                S_PI_MD: begin
                    if (r_wait && w_done) begin
                        r_wait    <= 1'b0;
                        r_tot     <= r_tot + w_res;
                        r_pe[r_w] <= r_e;
                        r_state   <= S_PI_DIV;
                    end
                end
                S_PI_DIV: begin
                    if (r_wait && w_done) begin
                        r_wait  <= 1'b0;
                        r_pid   <= w_pidc[21:0];
                        r_state <= S_PI_DUTY;
                    end
                end
                S_PI_DUTY: begin
                    if (r_wait && w_done) begin
                        r_wait      <= 1'b0;
                        r_duty[r_w] <= w_duty;
                        r_w         <= ~r_w;
                        r_state     <= r_w ? S_FINISH : S_PI_ERR;
                    end
                end
                // hand over once the output register is free
                S_FINISH: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_o_dl      <= r_duty[0];
                        r_o_dr      <= r_duty[1];
                        r_o_lin     <= r_lin;
                        r_o_ang     <= r_ang;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/dds_muldiv.sv
// bit-serial signed multiply and rounded divide unit
`default_nettype none

module dds_muldiv (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire dds_pkg::t_alu_req                i_req,
    input  wire logic signed [dds_pkg::ALU_W-1:0] i_a,
    input  wire logic        [dds_pkg::ALU_W-1:0] i_b,
    output logic                                  o_done,
    output logic signed [dds_pkg::ALU_W-1:0]      o_res
);
    import dds_pkg::*;

    logic            r_busy;
    logic            r_done;
    t_alu_op         r_op;
    logic            r_neg;
    logic [5:0]      r_cnt;
    logic [ALU_W-1:0] r_acc;
    logic [ALU_W-1:0] r_x;
    logic [31:0]     r_y;
    logic [ALU_W-1:0] r_d;
    logic [ALU_W-1:0] r_q;

    logic [ALU_W-1:0] w_amag;
    logic [31:0]      w_bmag;
    logic [ALU_W:0]   w_t;
    logic             w_ge;
    logic [ALU_W-1:0] w_val;

    assign w_amag = i_a[ALU_W-1] ? (~i_a + 1'b1) : i_a;
    assign w_bmag = i_b[31] ? (~i_b[31:0] + 1'b1) : i_b[31:0];
    // restoring divide step
    assign w_t    = {r_acc, r_x[ALU_W-1]};
    assign w_ge   = (w_t >= {1'b0, r_d});
    assign w_val  = (r_op == ALU_MUL) ? r_acc : r_q;
    assign o_res  = r_neg ? signed'(~w_val + 1'b1) : signed'(w_val);
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_op   <= i_req.op;
                r_acc  <= '0;
                r_q    <= '0;
                if (i_req.op == ALU_MUL) begin
                    r_neg <= i_a[ALU_W-1] ^ i_b[31];
                    r_x   <= w_amag;
                    r_y   <= w_bmag;
                    r_cnt <= 6'd31;
                end else begin
                    r_neg <= i_a[ALU_W-1];
                    r_x   <= w_amag + (i_b >> 1);
                    r_d   <= i_b;
                    r_cnt <= 6'd63;
                end
            end else if (r_busy) begin
                if (r_op == ALU_MUL) begin
                    if (r_y[0]) begin
                        r_acc <= r_acc + r_x;
                    end
                    r_x <= r_x << 1;
                    r_y <= r_y >> 1;
                end else begin
                    if (w_ge) begin
                        r_acc <= ALU_W'(w_t - {1'b0, r_d});
                    end else begin
                        r_acc <= w_t[ALU_W-1:0];
                    end
                    r_x <= r_x << 1;
                    r_q <= {r_q[ALU_W-2:0], w_ge};
                end
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: sv/dds_checker.sv
// port-level checks of the wheel speed controller and their bind
`default_nettype none

module dds_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_ready,
    input wire logic               o_out_valid,
    input wire logic               i_out_ready,
    input wire logic signed [15:0] o_duty_left,
    input wire logic signed [15:0] o_duty_right
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // one tick at a time: no transfer in the cycle after one
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while a tick is in work");

    // duty stays inside the clamp
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_duty_left != -16'sd32768) && (o_duty_right != -16'sd32768))
        else $error("duty outside clamp");

    // a fresh result needs a tick to have been taken before
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_ready || !$past(o_in_ready))
        else $error("result without a tick");

endmodule

bind diff_drive_wheel_speed_pi dds_checker u_dds_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_duty_left  (o_duty_left),
    .o_duty_right (o_duty_right)
);

`default_nettype wire
